// ===== rtl/core/csht_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csht_pkg
// shared types and constants of the chained scatter hash table
// ----------------------------------------------------------------------------
package csht_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int KEY_W        = 64;
    localparam int VAL_W        = 64;
    localparam int CNT_W        = 7;

    typedef enum logic [1:0] {
        REQ_LOOKUP = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_CLEAR  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_ABSENT = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

endpackage

// ===== rtl/core/csht_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csht_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module csht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/chained_scatter_hash_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_scatter_hash_table
// in-place chained hash table, 64-bit keys to 64-bit values
// ----------------------------------------------------------------------------
// One request at a time. Each memory step of the sequencer reads or writes one
// slot of a single-port slot memory (key, value and link side by side), and a
// read is split into an address step and a registered-data step. A lookup or
// update walks the key's chain; an insert adds a free-slot scan over the
// used-bit register (one slot per cycle, up to CAPACITY-1) and, when a foreign
// entry is displaced, a walk of that entry's chain.
// Used bits are flip-flops cleared at reset and by clear; slot contents are
// read only behind a set used bit. The result sits in an output register and
// the next request is taken once it has been delivered.
module chained_scatter_hash_table #(
    parameter int CAPACITY = csht_pkg::CAPACITY_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [1:0]                i_req_type,
    input  logic [csht_pkg::KEY_W-1:0] i_key,
    input  logic [csht_pkg::VAL_W-1:0] i_value,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic                      o_found,
    output logic [csht_pkg::VAL_W-1:0] o_result_value,
    output logic [1:0]                o_status,
    output logic [csht_pkg::CNT_W-1:0] o_entries_now,
    input  logic                      i_cfg_we,
    input  logic [csht_pkg::CNT_W-1:0] i_cfg_wdata
);

    localparam int AW    = $clog2(CAPACITY);
    localparam int LW    = AW + 1;
    localparam int KW    = csht_pkg::KEY_W;
    localparam int VW    = csht_pkg::VAL_W;
    localparam int CW    = csht_pkg::CNT_W;
    localparam int SW    = KW + VW + LW;
    localparam int RST_R = (CAPACITY * 7 / 8) > 127 ? 127 : (CAPACITY * 7 / 8);
    localparam int CAP_C = CAPACITY > 127 ? 127 : CAPACITY;
    localparam logic [LW-1:0] LEND = LW'(CAPACITY);

    typedef enum logic [4:0] {
        S_IDLE, S_FIND_RD, S_FIND_CHK, S_UPD_WR, S_INS_START, S_SCAN,
        S_HOME_RD, S_HOME_CHK, S_MOVE_WR, S_PREV_RD, S_PREV_CHK, S_PREV_WR,
        S_HOME_WR, S_LINK_WR, S_RM_RD, S_RM_CHK, S_RM_NXT_RD, S_RM_NXT_CHK,
        S_RM_WR, S_RM_PREV_WR, S_OUT
    } t_state;

    t_state              r_state;
    logic [1:0]          r_req;
    logic [KW-1:0]       r_key;
    logic [VW-1:0]       r_val;
    logic [CW-1:0]       r_max;
    logic [CW-1:0]       r_cnt;
    logic [CAPACITY-1:0] r_used;
    logic [AW-1:0]       r_cur;
    logic [AW-1:0]       r_prev;
    logic [AW-1:0]       r_free;
    logic [AW-1:0]       r_nxt;
    logic [LW-1:0]       r_steps;
    logic [LW-1:0]       r_hlink;
    logic [KW-1:0]       r_hkey;
    logic [VW-1:0]       r_hval;
    logic                r_first;
    logic                r_ovalid;
    logic                r_found;
    logic [VW-1:0]       r_rv;
    logic [1:0]          r_status;

    logic                m_we;
    logic [AW-1:0]       m_addr;
    logic [SW-1:0]       m_wdata;
    logic [SW-1:0]       m_rdata;
    logic [KW-1:0]       rd_key;
    logic [VW-1:0]       rd_val;
    logic [LW-1:0]       rd_link;
    logic [AW-1:0]       home;
    logic [AW-1:0]       scan_nx;
    logic [CW-1:0]       limit;

    assign rd_key  = m_rdata[SW-1 -: KW];
    assign rd_val  = m_rdata[LW +: VW];
    assign rd_link = m_rdata[LW-1:0];
    assign home    = r_key[AW-1:0];
    assign scan_nx = r_cur + AW'(1);
    assign limit   = (r_max < CW'(CAP_C)) ? r_max : CW'(CAP_C);

    csht_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_slots (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_addr  (m_addr),
        .i_wdata (m_wdata),
        .o_rdata (m_rdata)
    );

    always_comb begin
        m_we    = 1'b0;
        m_addr  = r_cur;
        m_wdata = {r_key, r_val, LEND};
        case (r_state)
            S_UPD_WR: begin
                m_we    = 1'b1;
                m_wdata = {r_key, r_val, r_hlink};
            end
            S_HOME_WR: begin
                m_we    = 1'b1;
                m_addr  = home;
                m_wdata = {r_key, r_val, LEND};
            end
            S_MOVE_WR: begin
                m_we    = 1'b1;
                m_addr  = r_free;
                m_wdata = {r_hkey, r_hval, r_hlink};
            end
            S_LINK_WR: begin
                m_we    = 1'b1;
                m_addr  = r_free;
                m_wdata = {r_key, r_val, r_hlink};
            end
            S_PREV_WR: begin
                m_we    = 1'b1;
                m_addr  = r_prev;
                m_wdata = {r_hkey, r_hval, LW'(r_free)};
            end
            S_RM_WR: begin
                m_we    = 1'b1;
                m_addr  = r_prev;
                m_wdata = {r_hkey, r_hval, r_hlink};
            end
            S_RM_PREV_WR: begin
                m_we    = 1'b1;
                m_addr  = r_prev;
                m_wdata = {r_hkey, r_hval, r_hlink};
            end
            S_HOME_RD: m_addr = home;
            default: m_addr = r_cur;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_max    <= CW'(RST_R);
            r_cnt    <= '0;
            r_used   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max <= i_cfg_wdata;
            end
            if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid && !r_ovalid) begin
                        r_req    <= i_req_type;
                        r_key    <= i_key;
                        r_val    <= i_value;
                        r_cur    <= i_key[AW-1:0];
                        r_prev   <= i_key[AW-1:0];
                        r_steps  <= '0;
                        r_first  <= 1'b1;
                        r_found  <= 1'b0;
                        r_rv     <= '0;
                        r_status <= csht_pkg::ST_DONE;
                        if (i_req_type == csht_pkg::REQ_CLEAR) begin
                            r_used  <= '0;
                            r_cnt   <= '0;
                            r_state <= S_OUT;
                        end else if (!r_used[i_key[AW-1:0]]) begin
                            if (i_req_type == csht_pkg::REQ_INSERT) begin
                                r_state <= S_INS_START;
                            end else begin
                                r_status <= csht_pkg::ST_ABSENT;
                                r_state  <= S_OUT;
                            end
                        end else if (i_req_type == csht_pkg::REQ_REMOVE) begin
                            r_state <= S_RM_RD;
                        end else begin
                            r_state <= S_FIND_RD;
                        end
                    end
                end
                S_FIND_RD: r_state <= S_FIND_CHK;
                S_FIND_CHK: begin
                    if (rd_key == r_key) begin
                        r_found <= 1'b1;
                        if (r_req == csht_pkg::REQ_LOOKUP) begin
                            r_rv    <= rd_val;
                            r_state <= S_OUT;
                        end else begin
                            r_hlink <= rd_link;
                            r_state <= S_UPD_WR;
                        end
                    end else if (rd_link >= LEND || r_steps == LW'(CAPACITY - 1)) begin
                        if (r_req == csht_pkg::REQ_LOOKUP) begin
                            r_status <= csht_pkg::ST_ABSENT;
                            r_state  <= S_OUT;
                        end else begin
                            r_state <= S_INS_START;
                        end
                    end else begin
                        r_cur   <= rd_link[AW-1:0];
                        r_steps <= r_steps + LW'(1);
                        r_state <= S_FIND_RD;
                    end
                end
                S_UPD_WR: r_state <= S_OUT;
                S_INS_START: begin
                    if (r_cnt >= limit) begin
                        r_status <= csht_pkg::ST_FULL;
                        r_state  <= S_OUT;
                    end else if (!r_used[home]) begin
                        r_used[home] <= 1'b1;
                        r_cnt        <= r_cnt + CW'(1);
                        r_state      <= S_HOME_WR;
                    end else begin
                        r_cur   <= home + AW'(1);
                        r_steps <= LW'(1);
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_steps >= LW'(CAPACITY)) begin
                        r_status <= csht_pkg::ST_FULL;
                        r_state  <= S_OUT;
                    end else if (!r_used[r_cur]) begin
                        r_free  <= r_cur;
                        r_state <= S_HOME_RD;
                    end else begin
                        r_cur   <= scan_nx;
                        r_steps <= r_steps + LW'(1);
                    end
                end
                S_HOME_RD: r_state <= S_HOME_CHK;
                S_HOME_CHK: begin
                    r_hkey  <= rd_key;
                    r_hval  <= rd_val;
                    r_hlink <= rd_link;
                    r_used[r_free] <= 1'b1;
                    r_cnt   <= r_cnt + CW'(1);
                    if (rd_key[AW-1:0] == home) begin
                        r_state <= S_LINK_WR;
                    end else begin
                        r_cur   <= rd_key[AW-1:0];
                        r_steps <= '0;
                        r_state <= S_MOVE_WR;
                    end
                end
                S_LINK_WR: begin
                    r_cur   <= home;
                    r_state <= S_PREV_RD;
                    r_first <= 1'b0;
                end
                S_MOVE_WR: r_state <= S_PREV_RD;
                S_PREV_RD: r_state <= S_PREV_CHK;
                S_PREV_CHK: begin
                    if (!r_first) begin
                        r_hkey  <= rd_key;
                        r_hval  <= rd_val;
                        r_prev  <= home;
                        r_state <= S_PREV_WR;
                    end else if (rd_link == LW'(home)) begin
                        r_hkey  <= rd_key;
                        r_hval  <= rd_val;
                        r_prev  <= r_cur;
                        r_state <= S_PREV_WR;
                    end else if (rd_link >= LEND || r_steps == LW'(CAPACITY - 1)) begin
                        r_state <= S_HOME_WR;
                    end else begin
                        r_cur   <= rd_link[AW-1:0];
                        r_steps <= r_steps + LW'(1);
                        r_state <= S_PREV_RD;
                    end
                end
                S_PREV_WR: r_state <= r_first ? S_HOME_WR : S_OUT;
                S_HOME_WR: r_state <= S_OUT;
                S_RM_RD: r_state <= S_RM_CHK;
                S_RM_CHK: begin
                    if (r_first && rd_key == r_key) begin
                        r_found <= 1'b1;
                        r_cnt   <= r_cnt - CW'(1);
                        if (rd_link >= LEND) begin
                            r_used[r_cur] <= 1'b0;
                            r_state       <= S_OUT;
                        end else begin
                            r_nxt   <= rd_link[AW-1:0];
                            r_cur   <= rd_link[AW-1:0];
                            r_state <= S_RM_NXT_RD;
                        end
                    end else if (!r_first && rd_key == r_key) begin
                        r_found <= 1'b1;
                        r_cnt   <= r_cnt - CW'(1);
                        r_used[r_cur] <= 1'b0;
                        r_hlink <= rd_link;
                        r_cur   <= r_prev;
                        r_state <= S_RM_NXT_RD;
                    end else if (rd_link >= LEND || r_steps == LW'(CAPACITY)) begin
                        r_status <= csht_pkg::ST_ABSENT;
                        r_state  <= S_OUT;
                    end else begin
                        r_first <= 1'b0;
                        r_prev  <= r_cur;
                        r_cur   <= rd_link[AW-1:0];
                        r_steps <= r_steps + LW'(1);
                        r_state <= S_RM_RD;
                    end
                end
                S_RM_NXT_RD: r_state <= S_RM_NXT_CHK;
                S_RM_NXT_CHK: begin
                    r_hkey <= rd_key;
                    r_hval <= rd_val;
                    if (r_first) begin
                        r_hlink <= rd_link;
                        r_used[r_nxt] <= 1'b0;
                        r_prev  <= home;
                        r_state <= S_RM_WR;
                    end else begin
                        r_state <= S_RM_PREV_WR;
                    end
                end
                S_RM_WR: r_state <= S_OUT;
                S_RM_PREV_WR: r_state <= S_OUT;
                S_OUT: begin
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall        = (r_state != S_IDLE) || r_ovalid;
    assign o_valid        = r_ovalid;
    assign o_found        = r_found;
    assign o_result_value = r_rv;
    assign o_status       = r_status;
    assign o_entries_now  = r_cnt;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(CAP_C))
        else $error("entry count above capacity");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall)
        else $error("ready while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && i_stall) |=> (r_ovalid && $stable(r_status) && $stable(r_cnt)))
        else $error("result lost under stall");
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == csht_pkg::ST_FULL) |-> !o_found)
        else $error("full status on a hit");

endmodule
